// File: design/designated_router_election_unit_defines.svh
// Assertion macros for the designated router election unit.
// Used by the checker module; no other dependencies.
`ifndef DESIGNATED_ROUTER_ELECTION_UNIT_DEFINES_SVH
`define DESIGNATED_ROUTER_ELECTION_UNIT_DEFINES_SVH

// clocked assertion with active-low reset disable
`define DRELU_ASSERT_CR(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// same, on the unit clock and reset
`define DRELU_ASSERT(lbl, prop, msg) \
    `DRELU_ASSERT_CR(lbl, i_clk, i_rst_n, prop, msg)

`endif

// File: design/drelu_pkg.sv
// Package for the designated router election unit.
// Types, role codes, register indexes and FSM states; no dependencies.
package drelu_pkg;

    localparam int unsigned ID_W   = 32;
    localparam int unsigned PRIO_W = 8;
    localparam int unsigned IDX_W  = 2;

    localparam logic [1:0] ROLE_WAITING = 2'd0;
    localparam logic [1:0] ROLE_OTHER   = 2'd1;
    localparam logic [1:0] ROLE_BACKUP  = 2'd2;
    localparam logic [1:0] ROLE_DR      = 2'd3;

    localparam logic [IDX_W-1:0] CFG_ROUTER_ID   = 2'd0;
    localparam logic [IDX_W-1:0] CFG_ROUTER_PRIO = 2'd1;
    localparam logic [IDX_W-1:0] CFG_IS_NBMA     = 2'd2;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [ID_W-1:0]   dr;
        logic [ID_W-1:0]   bdr;
        logic              two_way;
        logic [PRIO_W-1:0] prio;
    } t_nbr_entry;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN_A = 4'b0010,
        S_SCAN_B = 4'b0100,
        S_FIN    = 4'b1000
    } t_state;

endpackage

// File: design/drelu_nbr_mem.sv
// Neighbor table memory: one write port, one read port, registered read data.
// Depends on drelu_pkg.
module drelu_nbr_mem #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW    = 6
) (
    input  logic                  i_clk,
    input  logic                  i_wr_en,
    input  logic [AW-1:0]         i_wr_addr,
    input  drelu_pkg::t_nbr_entry i_wr_data,
    input  logic                  i_rd_en,
    input  logic [AW-1:0]         i_rd_addr,
    output drelu_pkg::t_nbr_entry o_rd_data
);
    import drelu_pkg::*;

    t_nbr_entry r_mem [DEPTH];
    t_nbr_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

// File: design/designated_router_election_unit.sv
// Designated router election unit, top level.
// Each input beat with a valid entry appends it to a table held in a single-port-read
// memory while the table has room; a beat marked last starts the election, which walks
// the table once for the backup and once for the DR, and again both if this router's
// own standing changes. The memory read port reads one entry per cycle. No item is
// taken during an election.
// Depends on drelu_pkg and drelu_nbr_mem.
module designated_router_election_unit #(
    parameter int unsigned MAX_NEIGHBORS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [drelu_pkg::IDX_W-1:0]   i_cfg_index,
    input  logic [31:0]                   i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_entry_valid,
    input  logic [31:0]                   i_neighbor_id,
    input  logic [7:0]                    i_neighbor_priority,
    input  logic                          i_neighbor_two_way,
    input  logic [31:0]                   i_neighbor_dr,
    input  logic [31:0]                   i_neighbor_bdr,
    input  logic                          i_last,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [31:0]                   o_elected_dr,
    output logic [31:0]                   o_elected_bdr,
    output logic [1:0]                    o_role,
    output logic                          o_role_changed,
    output logic                          o_left_waiting,
    output logic                          o_originate_network_ad,
    output logic                          o_start_zero_priority,
    output logic                          o_recheck_adjacency,
    output logic                          o_table_overflow
);
    import drelu_pkg::*;

    localparam int unsigned AW = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
    localparam int unsigned CW = $clog2(MAX_NEIGHBORS + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_NEIGHBORS);

    t_state r_state;
    logic [ID_W-1:0]   r_rid;
    logic [PRIO_W-1:0] r_rprio;
    logic              r_nbma;
    logic [CW-1:0]     r_count, r_idx;
    logic              r_ovf, r_pend, r_round, r_any_zero, r_any_two;
    logic [ID_W-1:0]   r_cur_dr, r_cur_bdr, r_dr_state, r_bdr_state;
    logic [1:0]        r_role_state;
    logic [ID_W-1:0]   r_bk_id, r_hi_id, r_dr_id, r_new_bdr;
    logic [PRIO_W-1:0] r_bk_p, r_hi_p, r_dr_p;
    logic              r_bk_decl, r_dr_decl;

    t_nbr_entry w_wr, w_rd;
    logic in_acc, wr_en, rd_en, scan_done;
    logic elig, decl_now, hi_upd, dr_upd;
    logic self_ok_a, t1, t2, tself, chg;
    logic [ID_W-1:0] bdr_fin, dr_fin;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign wr_en       = in_acc && i_entry_valid && (r_count < CNT_MAX);
    assign w_wr        = '{id: i_neighbor_id, dr: i_neighbor_dr, bdr: i_neighbor_bdr,
                           two_way: i_neighbor_two_way, prio: i_neighbor_priority};
    assign rd_en       = ((r_state == S_SCAN_A) || (r_state == S_SCAN_B)) && (r_idx < r_count);
    assign scan_done   = !rd_en && !r_pend;

    drelu_nbr_mem #(.DEPTH(MAX_NEIGHBORS), .AW(AW)) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_count[AW-1:0]),
        .i_wr_data (w_wr),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_idx[AW-1:0]),
        .o_rd_data (w_rd)
    );

    always_comb begin
        elig     = w_rd.two_way && (w_rd.prio != '0);
        decl_now = elig && (w_rd.dr != w_rd.id) && (w_rd.bdr == w_rd.id)
                   && ({w_rd.prio, w_rd.id} > {r_bk_p, r_bk_id});
        hi_upd   = elig && (w_rd.dr != w_rd.id) && !(r_bk_decl || decl_now)
                   && ({w_rd.prio, w_rd.id} > {r_hi_p, r_hi_id});
        dr_upd   = elig && (w_rd.dr == w_rd.id)
                   && ({w_rd.prio, w_rd.id} > {r_dr_p, r_dr_id});
        self_ok_a = (r_rprio != '0) && (r_cur_dr != r_rid);
        t1 = self_ok_a && (r_cur_bdr == r_rid) && ({r_rprio, r_rid} > {r_bk_p, r_bk_id});
        t2 = self_ok_a && !(r_bk_decl || t1) && ({r_rprio, r_rid} > {r_hi_p, r_hi_id});
        bdr_fin = (t1 || t2) ? r_rid : (r_bk_decl ? r_bk_id : r_hi_id);
        tself = (r_rprio != '0) && (r_cur_dr == r_rid)
                && ({r_rprio, r_rid} > {r_dr_p, r_dr_id});
        dr_fin = tself ? r_rid : (r_dr_decl ? r_dr_id : r_new_bdr);
        chg = ((dr_fin != '0) && ((r_cur_dr == r_rid) != (dr_fin == r_rid))) ||
              ((r_new_bdr != '0) && ((r_cur_bdr == r_rid) != (r_new_bdr == r_rid)));
    end

    // role transitions, applied in order
    logic was_bdr, was_dr, was_other, was_wait, is_bdr, is_dr, is_other;
    logic [1:0] n_role;
    logic n_chg, n_lw, n_na;
    always_comb begin
        was_bdr   = (r_bdr_state == r_rid);
        was_dr    = (r_dr_state == r_rid);
        was_other = (r_role_state == ROLE_OTHER);
        was_wait  = !was_bdr && !was_dr && !was_other;
        is_bdr    = (r_new_bdr == r_rid);
        is_dr     = (r_dr_id == r_rid);
        is_other  = !is_bdr && !is_dr;
        n_role = r_role_state;
        n_chg  = 1'b0;
        n_na   = 1'b0;
        if (was_bdr && is_dr) begin
            n_role = ROLE_DR; n_chg = 1'b1; n_na = 1'b1;
        end
        if (was_bdr && is_other) begin
            n_role = ROLE_OTHER; n_chg = 1'b1;
        end
        if (was_dr && is_bdr) begin
            n_role = ROLE_BACKUP; n_chg = 1'b1;
        end
        if (was_dr && is_other) begin
            n_role = ROLE_OTHER; n_chg = 1'b1;
        end
        if (was_other && is_dr) begin
            n_role = ROLE_DR; n_chg = 1'b1; n_na = 1'b1;
        end
        if (was_other && is_bdr) begin
            n_role = ROLE_BACKUP; n_chg = 1'b1;
        end
        if (was_wait && is_dr) begin
            n_role = ROLE_DR; n_chg = 1'b1; n_na = 1'b1;
        end
        if (was_wait && is_bdr) begin
            n_role = ROLE_BACKUP; n_chg = 1'b1;
        end
        if (was_wait && is_other) begin
            n_role = ROLE_OTHER; n_chg = 1'b1;
        end
        n_lw = n_chg && (r_role_state == ROLE_WAITING);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_rid        <= '0;
            r_rprio      <= PRIO_W'(1);
            r_nbma       <= 1'b0;
            r_count      <= '0;
            r_idx        <= '0;
            r_ovf        <= 1'b0;
            r_pend       <= 1'b0;
            r_round      <= 1'b0;
            r_dr_state   <= '0;
            r_bdr_state  <= '0;
            r_role_state <= ROLE_WAITING;
            o_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_ROUTER_ID:   r_rid   <= i_cfg_data;
                    CFG_ROUTER_PRIO: r_rprio <= i_cfg_data[PRIO_W-1:0];
                    CFG_IS_NBMA:     r_nbma  <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (o_out_valid && i_out_ready && (r_state != S_FIN)) begin
                o_out_valid <= 1'b0;
            end
            r_pend <= rd_en;
            if (rd_en) begin
                r_idx <= r_idx + CW'(1);
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (wr_en) begin
                            r_count <= r_count + CW'(1);
                        end else if (i_entry_valid) begin
                            r_ovf <= 1'b1;
                        end
                        if (i_last) begin
                            r_state    <= S_SCAN_A;
                            r_idx      <= '0;
                            r_round    <= 1'b0;
                            r_cur_dr   <= r_dr_state;
                            r_cur_bdr  <= r_bdr_state;
                            r_any_zero <= 1'b0;
                            r_any_two  <= 1'b0;
                            r_bk_id <= '0; r_bk_p <= '0; r_bk_decl <= 1'b0;
                            r_hi_id <= '0; r_hi_p <= '0;
                        end
                    end
                end
                S_SCAN_A: begin
                    if (r_pend) begin
                        if (w_rd.prio == '0) r_any_zero <= 1'b1;
                        if (w_rd.two_way)    r_any_two  <= 1'b1;
                        if (decl_now) begin
                            r_bk_id <= w_rd.id; r_bk_p <= w_rd.prio; r_bk_decl <= 1'b1;
                        end
                        if (hi_upd) begin
                            r_hi_id <= w_rd.id; r_hi_p <= w_rd.prio;
                        end
                    end
                    if (scan_done) begin
                        r_new_bdr <= bdr_fin;
                        r_state   <= S_SCAN_B;
                        r_idx     <= '0;
                        r_dr_id <= '0; r_dr_p <= '0; r_dr_decl <= 1'b0;
                    end
                end
                S_SCAN_B: begin
                    if (r_pend && dr_upd) begin
                        r_dr_id <= w_rd.id; r_dr_p <= w_rd.prio; r_dr_decl <= 1'b1;
                    end
                    if (scan_done) begin
                        r_dr_id <= dr_fin;
                        if (!r_round && chg) begin
                            r_round   <= 1'b1;
                            r_cur_dr  <= dr_fin;
                            r_cur_bdr <= r_new_bdr;
                            r_state   <= S_SCAN_A;
                            r_idx     <= '0;
                            r_bk_id <= '0; r_bk_p <= '0; r_bk_decl <= 1'b0;
                            r_hi_id <= '0; r_hi_p <= '0;
                        end else begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_FIN: begin
                    if (!o_out_valid || i_out_ready) begin
                        o_out_valid            <= 1'b1;
                        o_elected_dr           <= r_dr_id;
                        o_elected_bdr          <= r_new_bdr;
                        o_role                 <= n_role;
                        o_role_changed         <= n_chg;
                        o_left_waiting         <= n_lw;
                        o_originate_network_ad <= n_na;
                        o_start_zero_priority  <= r_nbma && r_any_zero &&
                                                  ((!was_bdr && is_bdr) || (!was_dr && is_dr));
                        o_recheck_adjacency    <= r_any_two && ((r_dr_id != r_dr_state) ||
                                                  (r_new_bdr != r_bdr_state));
                        o_table_overflow       <= r_ovf;
                        r_dr_state   <= r_dr_id;
                        r_bdr_state  <= r_new_bdr;
                        r_role_state <= n_role;
                        r_count      <= '0;
                        r_ovf        <= 1'b0;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// File: design/drelu_checker.sv
// Port-level checker for the designated router election unit, with its bind.
// Depends on designated_router_election_unit_defines.svh.
module drelu_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        i_last,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_elected_dr,
    input logic        o_role_changed,
    input logic        o_left_waiting,
    input logic        o_originate_network_ad
);
`include "designated_router_election_unit_defines.svh"

    `DRELU_ASSERT(a_out_hold, (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_elected_dr)), "result beat dropped or changed while stalled")
    `DRELU_ASSERT(a_no_early_out, (i_in_valid && o_in_ready && !i_last && !o_out_valid) |=> !o_out_valid, "result without a last beat")
    `DRELU_ASSERT(a_busy_after_last, (i_in_valid && o_in_ready && i_last) |=> !o_in_ready, "input taken during election")
    `DRELU_ASSERT(a_flags_need_change, (o_out_valid && !o_role_changed) |-> (!o_left_waiting && !o_originate_network_ad), "role action without transition")
endmodule

bind designated_router_election_unit drelu_checker u_drelu_checker (
    .i_clk                  (i_clk),
    .i_rst_n                (i_rst_n),
    .i_in_valid             (i_in_valid),
    .o_in_ready             (o_in_ready),
    .i_last                 (i_last),
    .o_out_valid            (o_out_valid),
    .i_out_ready            (i_out_ready),
    .o_elected_dr           (o_elected_dr),
    .o_role_changed         (o_role_changed),
    .o_left_waiting         (o_left_waiting),
    .o_originate_network_ad (o_originate_network_ad)
);

// File: tb/sv/designated_router_election_unit_checker.sv
// Checker for the designated router election unit: watches the input, config and
// result channels, predicts each election result and compares it field by field.
// Depends on drelu_pkg.
module designated_router_election_unit_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic        i_entry_valid,
    input  logic [31:0] i_neighbor_id,
    input  logic [7:0]  i_neighbor_priority,
    input  logic        i_neighbor_two_way,
    input  logic [31:0] i_neighbor_dr,
    input  logic [31:0] i_neighbor_bdr,
    input  logic        i_last,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [31:0] i_elected_dr,
    input  logic [31:0] i_elected_bdr,
    input  logic [1:0]  i_role,
    input  logic        i_role_changed,
    input  logic        i_left_waiting,
    input  logic        i_originate_network_ad,
    input  logic        i_start_zero_priority,
    input  logic        i_recheck_adjacency,
    input  logic        i_table_overflow,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_results_seen
);
    import drelu_pkg::*;

    localparam int TABLE_DEPTH = 64;

    typedef struct packed {
        logic [31:0] dr;
        logic [31:0] bdr;
        logic [1:0]  role;
        logic        changed;
        logic        left_wait;
        logic        net_ad;
        logic        start0;
        logic        recheck;
        logic        overflow;
    } t_election;

    t_election   election_q[$];
    t_nbr_entry  nbr_table[TABLE_DEPTH];
    int          nbr_cnt;
    logic        ovf_seen;
    logic [31:0] cur_dr, cur_bdr;
    logic [1:0]  cur_role;
    logic [31:0] own_id;
    logic [7:0]  own_prio;
    logic        nbma;

    function automatic bit outranks(logic [7:0] p, logic [31:0] id, logic [7:0] bp,
                                    logic [31:0] bid);
        return p > bp || (p == bp && id > bid);
    endfunction

    task automatic run_pass(input logic [31:0] dr_in, input logic [31:0] bdr_in,
                            output logic [31:0] dr_o, output logic [31:0] bdr_o);
        logic [31:0] bk_id, hi_id, d_id;
        logic [7:0]  bk_p, hi_p, d_p;
        bit          bk_decl, d_decl;
        t_nbr_entry  e;
        bk_id = 0; hi_id = 0; d_id = 0; bk_p = 0; hi_p = 0; d_p = 0;
        bk_decl = 0; d_decl = 0;
        for (int i = 0; i < nbr_cnt; i++) begin
            e = nbr_table[i];
            if (!e.two_way || e.prio == 0 || e.dr == e.id) continue;
            if (e.bdr == e.id && outranks(e.prio, e.id, bk_p, bk_id)) begin
                bk_id = e.id; bk_p = e.prio; bk_decl = 1;
            end
            if (!bk_decl && outranks(e.prio, e.id, hi_p, hi_id)) begin
                hi_id = e.id; hi_p = e.prio;
            end
        end
        if (own_prio > 0 && dr_in != own_id) begin
            if (bdr_in == own_id && outranks(own_prio, own_id, bk_p, bk_id)) begin
                bk_id = own_id; bk_p = own_prio; bk_decl = 1;
            end
            if (!bk_decl && outranks(own_prio, own_id, hi_p, hi_id)) begin
                bk_id = own_id; bk_p = own_prio; bk_decl = 1;
            end
        end
        if (!bk_decl) begin
            bk_id = hi_id; bk_p = hi_p;
        end
        for (int i = 0; i < nbr_cnt; i++) begin
            e = nbr_table[i];
            if (!e.two_way || e.prio == 0) continue;
            if (e.dr == e.id && outranks(e.prio, e.id, d_p, d_id)) begin
                d_id = e.id; d_p = e.prio; d_decl = 1;
            end
        end
        if (own_prio > 0 && dr_in == own_id && outranks(own_prio, own_id, d_p, d_id)) begin
            d_id = own_id; d_p = own_prio; d_decl = 1;
        end
        if (!d_decl) d_id = bk_id;
        dr_o = d_id;
        bdr_o = bk_id;
    endtask

    task automatic take_transition(input logic [1:0] tgt, input logic [1:0] orig,
                                   inout t_election r);
        r.role = tgt;
        r.changed = 1;
        if (orig == ROLE_WAITING) r.left_wait = 1;
        if (tgt == ROLE_DR) r.net_ad = 1;
    endtask

    task automatic elect_and_queue();
        logic [31:0] dr_w, bdr_w, ndr, nbdr;
        int          rounds;
        bit          was_bdr, was_dr, was_other, was_wait, is_bdr, is_dr, is_other;
        bit          any_zero, any_two;
        int          nt;
        t_election   r;
        dr_w = cur_dr; bdr_w = cur_bdr; ndr = 0; nbdr = 0; rounds = 0;
        r = '0;
        while (rounds < 2) begin
            run_pass(dr_w, bdr_w, ndr, nbdr);
            if ((ndr != 0 && ((dr_w == own_id) != (ndr == own_id))) ||
                (nbdr != 0 && ((bdr_w == own_id) != (nbdr == own_id)))) begin
                dr_w = ndr; bdr_w = nbdr; rounds++;
            end else begin
                rounds += 2;
            end
        end
        was_bdr = cur_bdr == own_id;
        was_dr = cur_dr == own_id;
        was_other = cur_role == ROLE_OTHER;
        was_wait = !was_bdr && !was_dr && !was_other;
        is_bdr = nbdr == own_id;
        is_dr = ndr == own_id;
        is_other = !is_bdr && !is_dr;
        r.role = cur_role;
        if (was_bdr) begin
            if (is_dr) take_transition(ROLE_DR, cur_role, r);
            if (is_other) take_transition(ROLE_OTHER, cur_role, r);
        end
        nt = 0;
        if (was_dr) begin
            if (is_bdr) begin take_transition(ROLE_BACKUP, cur_role, r); nt++; end
            if (is_other) begin take_transition(ROLE_OTHER, cur_role, r); nt++; end
        end
        if (was_other) begin
            if (is_dr && nt < 3) begin take_transition(ROLE_DR, cur_role, r); nt++; end
            if (is_bdr && nt < 3) begin take_transition(ROLE_BACKUP, cur_role, r); nt++; end
        end
        if (was_wait) begin
            if (is_dr) take_transition(ROLE_DR, cur_role, r);
            if (is_bdr) take_transition(ROLE_BACKUP, cur_role, r);
            if (is_other) take_transition(ROLE_OTHER, cur_role, r);
        end
        any_zero = 0; any_two = 0;
        for (int i = 0; i < nbr_cnt; i++) begin
            if (nbr_table[i].prio == 0) any_zero = 1;
            if (nbr_table[i].two_way) any_two = 1;
        end
        r.start0 = nbma && ((!was_bdr && is_bdr) || (!was_dr && is_dr)) && any_zero;
        r.recheck = (ndr != cur_dr || nbdr != cur_bdr) && any_two;
        r.overflow = ovf_seen;
        r.dr = ndr;
        r.bdr = nbdr;
        election_q.push_back(r);
        cur_dr = ndr; cur_bdr = nbdr; cur_role = r.role;
        nbr_cnt = 0; ovf_seen = 0;
    endtask

    task automatic report(input string what, input logic [31:0] exp_v, input logic [31:0] act_v);
        o_fail_count++;
        if (o_fail_count <= 10)
            $display("mismatch %s: expected %h actual %h at %0t", what, exp_v, act_v, $time);
    endtask

    always @(posedge i_clk) begin
        t_election exp_r;
        if (!i_rst_n) begin
            election_q.delete();
            nbr_cnt = 0; ovf_seen = 0; cur_dr = 0; cur_bdr = 0; cur_role = ROLE_WAITING;
            own_id = 0; own_prio = 1; nbma = 0;
            o_fail_count = 0;
            o_results_seen = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_ROUTER_ID:   own_id = i_cfg_data;
                    CFG_ROUTER_PRIO: own_prio = i_cfg_data[7:0];
                    CFG_IS_NBMA:     nbma = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                o_results_seen++;
                if (election_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10) $display("unexpected result beat at %0t", $time);
                end else begin
                    exp_r = election_q.pop_front();
                    if (exp_r.dr != i_elected_dr) report("elected_dr", exp_r.dr, i_elected_dr);
                    if (exp_r.bdr != i_elected_bdr)
                        report("elected_bdr", exp_r.bdr, i_elected_bdr);
                    if (exp_r.role != i_role) report("role", exp_r.role, i_role);
                    if (exp_r.changed != i_role_changed)
                        report("role_changed", exp_r.changed, i_role_changed);
                    if (exp_r.left_wait != i_left_waiting)
                        report("left_waiting", exp_r.left_wait, i_left_waiting);
                    if (exp_r.net_ad != i_originate_network_ad)
                        report("originate_network_ad", exp_r.net_ad, i_originate_network_ad);
                    if (exp_r.start0 != i_start_zero_priority)
                        report("start_zero_priority", exp_r.start0, i_start_zero_priority);
                    if (exp_r.recheck != i_recheck_adjacency)
                        report("recheck_adjacency", exp_r.recheck, i_recheck_adjacency);
                    if (exp_r.overflow != i_table_overflow)
                        report("table_overflow", exp_r.overflow, i_table_overflow);
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (i_entry_valid) begin
                    if (nbr_cnt < TABLE_DEPTH) begin
                        nbr_table[nbr_cnt] = '{id: i_neighbor_id, dr: i_neighbor_dr,
                            bdr: i_neighbor_bdr, two_way: i_neighbor_two_way,
                            prio: i_neighbor_priority};
                        nbr_cnt++;
                    end else begin
                        ovf_seen = 1;
                    end
                end
                if (i_last) elect_and_queue();
            end
        end
        o_pending = election_q.size();
    end
endmodule

// File: tb/sv/designated_router_election_unit_test.sv
// Testbench top for the designated router election unit: drives neighbor batches and
// register writes with random idling and back-pressure, and reports the verdict.
// Depends on drelu_pkg, the unit and designated_router_election_unit_checker.
module designated_router_election_unit_test;
    import drelu_pkg::*;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = CFG_ROUTER_ID;
    logic [31:0] cfg_data = 0;
    logic        in_valid = 0;
    logic        in_ready;
    logic        entry_valid = 0;
    logic [31:0] nbr_id = 0, nbr_dr = 0, nbr_bdr = 0;
    logic [7:0]  nbr_prio = 0;
    logic        nbr_two_way = 0;
    logic        last = 0;
    logic        out_valid;
    logic        out_ready = 0;
    logic [31:0] el_dr, el_bdr;
    logic [1:0]  el_role;
    logic        el_changed, el_left, el_netad, el_start0, el_recheck, el_ovf;
    int          fail_count, pending, results_seen;
    int          send_idle_pct = 0, recv_idle_pct = 0;
    bit          recv_hold = 0;
    int          items_sent = 0, batches_sent = 0;
    logic [31:0] own_id = 0;
    logic [31:0] id_pool[8];

    always #4 i_clk = ~i_clk;

    designated_router_election_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_entry_valid(entry_valid), .i_neighbor_id(nbr_id),
        .i_neighbor_priority(nbr_prio), .i_neighbor_two_way(nbr_two_way),
        .i_neighbor_dr(nbr_dr), .i_neighbor_bdr(nbr_bdr), .i_last(last),
        .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_elected_dr(el_dr), .o_elected_bdr(el_bdr), .o_role(el_role),
        .o_role_changed(el_changed), .o_left_waiting(el_left),
        .o_originate_network_ad(el_netad), .o_start_zero_priority(el_start0),
        .o_recheck_adjacency(el_recheck), .o_table_overflow(el_ovf)
    );

    designated_router_election_unit_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .i_in_ready(in_ready),
        .i_entry_valid(entry_valid), .i_neighbor_id(nbr_id),
        .i_neighbor_priority(nbr_prio), .i_neighbor_two_way(nbr_two_way),
        .i_neighbor_dr(nbr_dr), .i_neighbor_bdr(nbr_bdr), .i_last(last),
        .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_elected_dr(el_dr), .i_elected_bdr(el_bdr), .i_role(el_role),
        .i_role_changed(el_changed), .i_left_waiting(el_left),
        .i_originate_network_ad(el_netad), .i_start_zero_priority(el_start0),
        .i_recheck_adjacency(el_recheck), .i_table_overflow(el_ovf),
        .o_fail_count(fail_count), .o_pending(pending), .o_results_seen(results_seen)
    );

    always @(negedge i_clk) begin
        out_ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge i_clk); while (!cfg_ready);
        @(negedge i_clk);
        cfg_valid <= 0;
        if (idx == CFG_ROUTER_ID) own_id = val;
    endtask

    task automatic drain();
        while (pending != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic send_beat(input bit ev, input logic [31:0] id, input logic [7:0] p,
                             input bit tw, input logic [31:0] d, input logic [31:0] b,
                             input bit lst);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 0;
            @(negedge i_clk);
        end
        in_valid <= 1;
        entry_valid <= ev; nbr_id <= id; nbr_prio <= p; nbr_two_way <= tw;
        nbr_dr <= d; nbr_bdr <= b; last <= lst;
        do @(posedge i_clk); while (!in_ready);
        items_sent++;
        if (lst) batches_sent++;
    endtask

    task automatic end_burst();
        @(negedge i_clk);
        in_valid <= 0;
    endtask

    function automatic logic [31:0] pick_id();
        case ($urandom_range(9))
            0: return own_id;
            1: return 32'hFFFF_FFFF;
            2: return 0;
            default: return id_pool[$urandom_range(7)];
        endcase
    endfunction

    function automatic logic [7:0] pick_prio();
        case ($urandom_range(7))
            0: return 0;
            1: return 8'hFF;
            2, 3: return 8'($urandom_range(1, 3));
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic random_batch(input int n);
        logic [31:0] id, d, b;
        bit          tw;
        for (int k = 0; k < n; k++) begin
            id = ($urandom_range(9) == 0) ? $urandom : id_pool[$urandom_range(7)];
            d = ($urandom_range(2) == 0) ? id : pick_id();
            b = ($urandom_range(2) == 0) ? id : pick_id();
            tw = $urandom_range(5) != 0;
            send_beat($urandom_range(19) != 0, id, pick_prio(), tw, d, b, k == n - 1);
        end
    endtask

    task automatic new_pool();
        for (int k = 0; k < 8; k++) id_pool[k] = $urandom;
        id_pool[0] = 32'hFFFF_FFFF;
        id_pool[1] = 1;
    endtask

    task automatic random_phase(input int budget);
        int stop_at;
        stop_at = items_sent + budget;
        while (items_sent < stop_at) begin
            random_batch(($urandom_range(9) == 0) ? $urandom_range(60, 70)
                                                  : $urandom_range(1, 8));
            if ($urandom_range(3) == 0) end_burst();
        end
        end_burst();
    endtask

    initial begin
        #2_000_000;
        $display("timeout");
        $display("designated_router_election_unit_test: FAIL");
        $finish;
    end

    initial begin
        new_pool();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // directed: default config, empty election, then own router wins
        send_beat(0, 0, 0, 0, 0, 0, 1);
        send_beat(1, 32'hFFFF_FFFF, 8'hFF, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        send_beat(1, 32'h0000_0005, 8'h00, 1, 0, 0, 0);
        send_beat(1, 32'h0000_0007, 8'h80, 0, 7, 7, 1);
        end_burst();
        drain();
        write_reg(CFG_ROUTER_ID, 32'hFFFF_FFFF);
        write_reg(CFG_ROUTER_PRIO, 8'hFF);
        write_reg(CFG_IS_NBMA, 1);
        send_beat(1, 32'h0000_0010, 8'h00, 1, 0, 0, 1);
        send_beat(1, 32'h0000_0011, 8'hFF, 1, 32'h11, 0, 1);
        send_beat(1, 32'h0000_0012, 8'h01, 1, 0, 32'h12, 1);
        end_burst();
        drain();
        write_reg(CFG_ROUTER_PRIO, 0);
        send_beat(1, 32'h20, 8'h05, 1, 0, 0, 0);
        send_beat(1, 32'h21, 8'h05, 1, 0, 0, 1);
        end_burst();
        drain();
        write_reg(CFG_ROUTER_ID, 0);
        write_reg(CFG_IS_NBMA, 0);
        write_reg(CFG_ROUTER_PRIO, 1);
        // overflow: 66 entries in one batch
        for (int k = 0; k < 66; k++) send_beat(1, 32'(k + 100), 8'(k), k[0], 0, 0, k == 65);
        end_burst();
        drain();

        send_idle_pct = 34; recv_idle_pct = 73;
        random_phase(650);
        drain();
        write_reg(CFG_ROUTER_ID, id_pool[2]);
        write_reg(CFG_ROUTER_PRIO, 8'hFF);
        write_reg(CFG_IS_NBMA, 1);
        new_pool();
        id_pool[3] = own_id;

        send_idle_pct = 73; recv_idle_pct = 34;
        fork
            begin
                recv_hold = 1;
                repeat (400) @(posedge i_clk);
                recv_hold = 0;
            end
            random_phase(650);
        join
        drain();
        write_reg(CFG_ROUTER_PRIO, 0);
        write_reg(CFG_ROUTER_ID, 32'hFFFF_FFFF);
        write_reg(CFG_IS_NBMA, 0);

        send_idle_pct = 0; recv_idle_pct = 0;
        random_phase(300);
        drain();
        write_reg(CFG_ROUTER_PRIO, $urandom_range(1, 254));
        write_reg(CFG_ROUTER_ID, id_pool[5]);
        random_phase(300);
        drain();

        $display("ran %0d input beats in %0d elections, %0d results checked",
                 items_sent, batches_sent, results_seen);
        if (fail_count == 0)
            $display("designated_router_election_unit_test: PASS");
        else
            $display("designated_router_election_unit_test: FAIL");
        $finish;
    end
endmodule

// File: filelist.f
+incdir+design
design/drelu_pkg.sv
design/drelu_nbr_mem.sv
design/designated_router_election_unit.sv
design/drelu_checker.sv
tb/sv/designated_router_election_unit_checker.sv
tb/sv/designated_router_election_unit_test.sv
